[rtl/dcc_loco_packet_former_unit_macros.svh]
// ---------------------------------------------------------------------------
// dcc loco packet former assertion macros
// shared concurrent assertion forms for the packet former rtl
// ---------------------------------------------------------------------------
`ifndef DCC_LOCO_PACKET_FORMER_UNIT_MACROS_SVH
`define DCC_LOCO_PACKET_FORMER_UNIT_MACROS_SVH

// same-cycle implication
`define DLPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLPF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/dcc_lpf_pkg.sv]
// ---------------------------------------------------------------------------
// dcc loco packet former package
// shared types, opcodes and widths for the packet former
// ---------------------------------------------------------------------------
`default_nettype none

package dcc_lpf_pkg;

   localparam int FUNC_MAX               = 29;
   localparam int FUNCTION_COUNT_DEFAULT = 29;
   localparam int ADDR_W                 = 14;
   localparam int SPEED_W                = 7;
   localparam int BYTE_W                 = 8;
   localparam int LEN_W                  = 3;
   localparam int REQ_DATA_W             = 40;
   localparam int REQ_USER_W             = 3;
   localparam int RSP_DATA_W             = 40;

   localparam logic [SPEED_W-1:0] SPEED_MAX        = 7'd126;
   localparam logic [ADDR_W-1:0]  SHORT_ADDR_MAX   = 14'd127;
   localparam logic [BYTE_W-1:0]  LONG_ADDR_PREFIX = 8'hC0;
   localparam logic [BYTE_W-1:0]  SPEED_ESTOP      = 8'h01;

   // instruction bytes
   localparam logic [BYTE_W-1:0] OP_SPEED128  = 8'h3F;
   localparam logic [BYTE_W-1:0] OP_GROUP_F0  = 8'h80;
   localparam logic [BYTE_W-1:0] OP_GROUP_F5  = 8'hB0;
   localparam logic [BYTE_W-1:0] OP_GROUP_F9  = 8'hA0;
   localparam logic [BYTE_W-1:0] OP_EXP_F13   = 8'hDE;
   localparam logic [BYTE_W-1:0] OP_EXP_F21   = 8'hDF;
   localparam logic [3:0]        NIB_GROUP_F9 = 4'hA;
   localparam logic [3:0]        NIB_GROUP_F5 = 4'hB;
   localparam logic [2:0]        TOP_GROUP_F0 = 3'b100;

   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   typedef enum logic [1:0] {
      MODE_THROTTLE = 2'd0,
      MODE_FUNCTION = 2'd1,
      MODE_REFRESH  = 2'd2,
      MODE_ESTOP    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PKT_SPEED   = 3'd0,
      PKT_F0_F4   = 3'd1,
      PKT_F5_F8   = 3'd2,
      PKT_F9_F12  = 3'd3,
      PKT_F13_F20 = 3'd4,
      PKT_F21_F28 = 3'd5
   } pkt_idx_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   speed_byte;
      logic [FUNC_MAX-1:0] functions;
   } burst_type;

endpackage

`default_nettype wire

[rtl/dcc_lpf_state.sv]
// ---------------------------------------------------------------------------
// dcc loco packet former state
// locomotive state registers, command decode and burst descriptor
// ---------------------------------------------------------------------------
`default_nettype none

module dcc_lpf_state #(
   parameter int FUNCTION_COUNT = dcc_lpf_pkg::FUNCTION_COUNT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire dcc_lpf_pkg::mode_type            mode,
   input  wire logic [dcc_lpf_pkg::ADDR_W-1:0]   loco_address,
   input  wire logic [dcc_lpf_pkg::SPEED_W-1:0]  speed_step,
   input  wire logic                             direction,
   input  wire logic [dcc_lpf_pkg::BYTE_W-1:0]   function_byte,
   input  wire logic [dcc_lpf_pkg::BYTE_W-1:0]   second_byte,
   input  wire logic                             has_second,
   output logic                                  start,
   output dcc_lpf_pkg::burst_type                burst
);
   import dcc_lpf_pkg::*;

   logic [ADDR_W-1:0]         address_ff,   address_in;
   logic [SPEED_W-1:0]        speed_ff,     speed_in;
   logic                      direction_ff, direction_in;
   logic [FUNCTION_COUNT-1:0] func_ff,      func_in;
   logic                      stop_ff,      stop_in;

   logic [ADDR_W-1:0]   addr_cmd;
   logic [SPEED_W-1:0]  speed_cmd;
   logic                dir_cmd;
   logic                stop_cmd;
   logic [FUNC_MAX-1:0] func_cmd;

   always_comb begin
      addr_cmd  = address_ff;
      speed_cmd = speed_ff;
      dir_cmd   = direction_ff;
      stop_cmd  = stop_ff;
      func_cmd  = FUNC_MAX'(func_ff);
      if (accept) begin
         case (mode)
            MODE_THROTTLE: begin
               addr_cmd  = loco_address;
               speed_cmd = (speed_step > SPEED_MAX) ? SPEED_MAX : speed_step;
               dir_cmd   = direction;
               stop_cmd  = 1'b0;
            end
            MODE_FUNCTION: begin
               addr_cmd = loco_address;
               if (has_second) begin
                  if (function_byte == OP_EXP_F13) begin
                     func_cmd[20:13] = second_byte;
                  end else if (function_byte == OP_EXP_F21) begin
                     func_cmd[28:21] = second_byte;
                  end
               end else if (function_byte[7:4] == NIB_GROUP_F9) begin
                  func_cmd[12:9] = function_byte[3:0];
               end else if (function_byte[7:4] == NIB_GROUP_F5) begin
                  func_cmd[8:5] = function_byte[3:0];
               end else if (function_byte[7:5] == TOP_GROUP_F0) begin
                  func_cmd[0]   = function_byte[4];
                  func_cmd[4:1] = function_byte[3:0];
               end
            end
            MODE_REFRESH: begin
            end
            MODE_ESTOP: begin
               stop_cmd = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign start = accept && (mode != MODE_ESTOP);

   always_comb begin
      address_in   = addr_cmd;
      speed_in     = speed_cmd;
      direction_in = dir_cmd;
      func_in      = func_cmd[FUNCTION_COUNT-1:0];
      stop_in      = stop_cmd;
      burst.address    = addr_cmd;
      burst.functions  = FUNC_MAX'(func_in);
      burst.speed_byte = {dir_cmd, speed_cmd + SPEED_W'(speed_cmd != '0)};
      if (start && stop_cmd) begin
         burst.speed_byte = SPEED_ESTOP;
         stop_in          = 1'b0;
         speed_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= '0;
         speed_ff     <= '0;
         direction_ff <= 1'b0;
         func_ff      <= '0;
         stop_ff      <= 1'b0;
      end else begin
         address_ff   <= address_in;
         speed_ff     <= speed_in;
         direction_ff <= direction_in;
         func_ff      <= func_in;
         stop_ff      <= stop_in;
      end
   end

endmodule

`default_nettype wire

[rtl/dcc_lpf_emit.sv]
// ---------------------------------------------------------------------------
// dcc loco packet former emitter
// burst snapshot, packet sequencer and registered result stage
// ---------------------------------------------------------------------------
`default_nettype none
`include "dcc_loco_packet_former_unit_macros.svh"

module dcc_lpf_emit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire dcc_lpf_pkg::burst_type              burst,
   output logic                                     free,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // packet_length[2:0], byte_zero[10:3], byte_one[18:11],
   // byte_two[26:19], byte_three[34:27], zero pad
   output logic [dcc_lpf_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                     rsp_tlast
);
   import dcc_lpf_pkg::*;

   burst_type   snap_ff;
   logic        busy_ff,  busy_in;
   pkt_idx_type count_ff, count_in;

   logic                  out_valid_ff, out_valid_in;
   logic [LEN_W-1:0]      len_ff,       len_in;
   logic [BYTE_W-1:0]     b0_ff, b1_ff, b2_ff, b3_ff;
   logic [BYTE_W-1:0]     b0_in, b1_in, b2_in, b3_in;
   logic                  last_ff,      last_in;

   logic              load;
   logic              at_last;
   logic              long_addr;
   logic [BYTE_W-1:0] d0;
   logic [BYTE_W-1:0] d1;
   logic              two;

   assign load      = busy_ff && (!out_valid_ff || rsp_tready);
   assign at_last   = (count_ff == PKT_F21_F28);
   assign free      = !busy_ff || (load && at_last);
   assign long_addr = (snap_ff.address > SHORT_ADDR_MAX);

   always_comb begin
      d0  = '0;
      d1  = '0;
      two = 1'b0;
      case (count_ff)
         PKT_SPEED: begin
            d0  = OP_SPEED128;
            d1  = snap_ff.speed_byte;
            two = 1'b1;
         end
         PKT_F0_F4: begin
            d0 = OP_GROUP_F0 | {3'b000, snap_ff.functions[0], snap_ff.functions[4:1]};
         end
         PKT_F5_F8: begin
            d0 = OP_GROUP_F5 | {4'h0, snap_ff.functions[8:5]};
         end
         PKT_F9_F12: begin
            d0 = OP_GROUP_F9 | {4'h0, snap_ff.functions[12:9]};
         end
         PKT_F13_F20: begin
            d0  = OP_EXP_F13;
            d1  = snap_ff.functions[20:13];
            two = 1'b1;
         end
         PKT_F21_F28: begin
            d0  = OP_EXP_F21;
            d1  = snap_ff.functions[28:21];
            two = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      len_in       = len_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      last_in      = last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         last_in      = at_last;
         if (long_addr) begin
            len_in = two ? LEN_FOUR : LEN_THREE;
            b0_in  = LONG_ADDR_PREFIX | {2'b00, snap_ff.address[13:8]};
            b1_in  = snap_ff.address[7:0];
            b2_in  = d0;
            b3_in  = two ? d1 : '0;
         end else begin
            len_in = two ? LEN_THREE : LEN_TWO;
            b0_in  = snap_ff.address[7:0];
            b1_in  = d0;
            b2_in  = two ? d1 : '0;
            b3_in  = '0;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (load) begin
         count_in = pkt_idx_type'(count_ff + 3'd1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (start) begin
         busy_in  = 1'b1;
         count_in = PKT_SPEED;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         snap_ff <= burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= PKT_SPEED;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      b2_ff   <= b2_in;
      b3_ff   <= b3_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = RSP_DATA_W'({b3_ff, b2_ff, b1_ff, b0_ff, len_ff});

   `DLPF_ASSERT_IMP(a_count_range, clock, reset, busy_ff, count_ff <= PKT_F21_F28,
      "packet index out of range")
   `DLPF_ASSERT_NXT(a_start_first, clock, reset, start,
      busy_ff && (count_ff == PKT_SPEED), "burst did not start at speed packet")
   `DLPF_ASSERT_NXT(a_end_idle, clock, reset, load && at_last && !start,
      !busy_ff && rsp_tvalid && rsp_tlast, "burst did not close on last packet")
   `DLPF_ASSERT_IMP(a_start_free, clock, reset, start, free,
      "burst started while sequencer occupied")

endmodule

`default_nettype wire

[rtl/dcc_loco_packet_former_unit.sv]
// first packet: registered in the result stage after the command loads the burst snapshot
// packets: six per burst, one per cycle from the packet sequencer while the receiver is ready;
//   next command taken in the cycle the sixth packet enters the result register
// emergency stop: taken without starting a burst, emits no packet
// reset: synchronous, clears locomotive state, stop flag, sequencer and result valid
// ---------------------------------------------------------------------------
// dcc loco packet former unit
// single locomotive state keeper emitting six-packet dcc refresh bursts
// ---------------------------------------------------------------------------
`default_nettype none

module dcc_loco_packet_former_unit #(
   parameter int FUNCTION_COUNT = dcc_lpf_pkg::FUNCTION_COUNT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // loco_address[13:0], speed_step[20:14], direction[21],
   // function_byte[29:22], second_byte[37:30], zero pad
   input  wire logic [dcc_lpf_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0], has_second[2]
   input  wire logic [dcc_lpf_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // packet_length[2:0], byte_zero[10:3], byte_one[18:11],
   // byte_two[26:19], byte_three[34:27], zero pad
   output logic [dcc_lpf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                    rsp_tlast
);
   import dcc_lpf_pkg::*;

   logic      accept;
   logic      start;
   logic      free;
   burst_type burst;

   assign req_tready = free;
   assign accept     = req_tvalid && free;

   dcc_lpf_state #(
      .FUNCTION_COUNT (FUNCTION_COUNT)
   ) u_state (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (mode_type'(req_tuser[1:0])),
      .loco_address  (req_tdata[13:0]),
      .speed_step    (req_tdata[20:14]),
      .direction     (req_tdata[21]),
      .function_byte (req_tdata[29:22]),
      .second_byte   (req_tdata[37:30]),
      .has_second    (req_tuser[2]),
      .start         (start),
      .burst         (burst)
   );

   dcc_lpf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .burst      (burst),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[tb/dcc_loco_packet_former_checker.sv]
// ---------------------------------------------------------------------------
// dcc loco packet former checker
// watches the command and packet streams, keeps its own copy of the
// locomotive state, predicts every packet of each burst and compares
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module dcc_loco_packet_former_checker #(
   parameter int FUNCTION_COUNT = dcc_lpf_pkg::FUNCTION_COUNT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // loco_address[13:0], speed_step[20:14], direction[21],
   // function_byte[29:22], second_byte[37:30], zero pad
   input  wire logic [dcc_lpf_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0], has_second[2]
   input  wire logic [dcc_lpf_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // packet_length[2:0], byte_zero[10:3], byte_one[18:11],
   // byte_two[26:19], byte_three[34:27], zero pad
   input  wire logic [dcc_lpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                              rsp_tlast,
   output int                                     fail_count,
   output int                                     pending_packets
);
   import dcc_lpf_pkg::*;

   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [BYTE_W-1:0] b3;
      logic              last;
   } dcc_packet_type;

   localparam logic [FUNC_MAX-1:0] FN_MASK = FUNC_MAX'((64'd1 << FUNCTION_COUNT) - 1);

   logic [ADDR_W-1:0]   loco_addr;
   logic [SPEED_W-1:0]  loco_speed;
   logic                loco_dir;
   logic [FUNC_MAX-1:0] fn_bits;
   logic                estop_pending;
   dcc_packet_type      packet_q[$];

   function automatic dcc_packet_type form_packet(input logic [BYTE_W-1:0] d0,
                                                  input logic [BYTE_W-1:0] d1,
                                                  input int n, input logic last);
      logic [BYTE_W-1:0] b [4];
      int                base;
      dcc_packet_type    p;
      b = '{default: '0};
      if (loco_addr > SHORT_ADDR_MAX) begin
         b[0] = LONG_ADDR_PREFIX | {2'b00, loco_addr[13:8]};
         b[1] = loco_addr[7:0];
         base = 2;
      end else begin
         b[0] = loco_addr[7:0];
         base = 1;
      end
      b[base] = d0;
      if (n == 2) begin
         b[base+1] = d1;
      end
      p.length = LEN_W'(base + n);
      p.b0     = b[0];
      p.b1     = b[1];
      p.b2     = b[2];
      p.b3     = b[3];
      p.last   = last;
      return p;
   endfunction

   function automatic void queue_packet(input dcc_packet_type p);
      packet_q.insert(packet_q.size(), p);
   endfunction

   function automatic void load_functions(input int first, input int count,
                                          input logic [BYTE_W-1:0] value);
      logic [FUNC_MAX-1:0] m;
      m = FUNC_MAX'(((32'd1 << count) - 1) << first) & FN_MASK;
      fn_bits = (fn_bits & ~m) | (FUNC_MAX'(32'(value) << first) & m);
   endfunction

   function automatic void queue_burst();
      logic [BYTE_W-1:0] speed_code;
      if (estop_pending) begin
         speed_code    = SPEED_ESTOP;
         estop_pending = 1'b0;
         loco_speed    = '0;
      end else begin
         speed_code = BYTE_W'(loco_speed) + ((loco_speed != 0) ? 8'd1 : 8'd0)
                      + (loco_dir ? 8'h80 : 8'h00);
      end
      queue_packet(form_packet(OP_SPEED128, speed_code, 2, 1'b0));
      queue_packet(form_packet(OP_GROUP_F0 | {3'b000, fn_bits[0], fn_bits[4:1]},
                               '0, 1, 1'b0));
      queue_packet(form_packet(OP_GROUP_F5 | {4'h0, fn_bits[8:5]}, '0, 1, 1'b0));
      queue_packet(form_packet(OP_GROUP_F9 | {4'h0, fn_bits[12:9]}, '0, 1, 1'b0));
      queue_packet(form_packet(OP_EXP_F13, fn_bits[20:13], 2, 1'b0));
      queue_packet(form_packet(OP_EXP_F21, fn_bits[28:21], 2, 1'b1));
   endfunction

   function automatic void take_command(input logic [REQ_DATA_W-1:0] data,
                                        input logic [REQ_USER_W-1:0] user);
      mode_type            mode;
      logic [SPEED_W-1:0]  spd;
      logic [BYTE_W-1:0]   fb;
      logic [BYTE_W-1:0]   sb;
      logic                has2;
      mode = mode_type'(user[1:0]);
      has2 = user[2];
      spd  = data[20:14];
      fb   = data[29:22];
      sb   = data[37:30];
      case (mode)
         MODE_ESTOP: begin
            estop_pending = 1'b1;
         end
         MODE_THROTTLE: begin
            loco_addr     = data[13:0];
            loco_speed    = (spd > SPEED_MAX) ? SPEED_MAX : spd;
            loco_dir      = data[21];
            estop_pending = 1'b0;
            queue_burst();
         end
         MODE_FUNCTION: begin
            loco_addr = data[13:0];
            if (has2) begin
               if (fb == OP_EXP_F13) begin
                  load_functions(13, 8, sb);
               end else if (fb == OP_EXP_F21) begin
                  load_functions(21, 8, sb);
               end
            end else if (fb[7:4] == NIB_GROUP_F9) begin
               load_functions(9, 4, {4'h0, fb[3:0]});
            end else if (fb[7:4] == NIB_GROUP_F5) begin
               load_functions(5, 4, {4'h0, fb[3:0]});
            end else if (fb[7:5] == TOP_GROUP_F0) begin
               load_functions(0, 1, {7'h00, fb[4]});
               load_functions(1, 4, {4'h0, fb[3:0]});
            end
            queue_burst();
         end
         default: begin
            queue_burst();
         end
      endcase
   endfunction

   always @(posedge clock) begin
      dcc_packet_type got;
      dcc_packet_type want;
      if (reset) begin
         loco_addr     = '0;
         loco_speed    = '0;
         loco_dir      = 1'b0;
         fn_bits       = '0;
         estop_pending = 1'b0;
         packet_q.delete();
         fail_count    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.length = rsp_tdata[2:0];
            got.b0     = rsp_tdata[10:3];
            got.b1     = rsp_tdata[18:11];
            got.b2     = rsp_tdata[26:19];
            got.b3     = rsp_tdata[34:27];
            got.last   = rsp_tlast;
            if (packet_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: unexpected packet len %0d bytes %h %h %h %h last %b",
                           $realtime, got.length, got.b0, got.b1, got.b2, got.b3,
                           got.last);
               end
               fail_count++;
            end else begin
               want = packet_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("%0t: packet mismatch", $realtime);
                     $display("   expected len %0d bytes %h %h %h %h last %b",
                              want.length, want.b0, want.b1, want.b2, want.b3, want.last);
                     $display("   actual   len %0d bytes %h %h %h %h last %b",
                              got.length, got.b0, got.b1, got.b2, got.b3, got.last);
                  end
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            take_command(req_tdata, req_tuser);
         end
      end
      pending_packets <= packet_q.size();
   end

endmodule

[tb/tb_dcc_loco_packet_former_unit.sv]
// ---------------------------------------------------------------------------
// dcc loco packet former unit testbench
// directed and random command streams with sender gaps, receiver stalls and
// a long receiver hold-off; the checker predicts and compares every packet
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dcc_loco_packet_former_unit;
   import dcc_lpf_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // loco_address[13:0], speed_step[20:14], direction[21],
   // function_byte[29:22], second_byte[37:30], zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   // mode[1:0], has_second[2]
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // packet_length[2:0], byte_zero[10:3], byte_one[18:11],
   // byte_two[26:19], byte_three[34:27], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int   fail_count;
   int   pending_packets;
   int   idle_pct;
   int   stall_pct;
   logic hold_req;
   logic hold_active;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   dcc_loco_packet_former_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   dcc_loco_packet_former_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending_packets (pending_packets)
   );

   always @(posedge clock) begin
      rsp_tready <= !hold_active && ($urandom_range(99) >= stall_pct);
   end

   // long receiver hold-off while commands keep coming
   initial begin : hold_off
      int n;
      hold_active = 1'b0;
      @(posedge hold_req);
      hold_active <= 1'b1;
      for (n = 0; n < 300; n++) begin
         @(posedge clock);
      end
      hold_active <= 1'b0;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic send_command(input mode_type mode, input logic [ADDR_W-1:0] addr,
                               input logic [SPEED_W-1:0] spd, input logic dir,
                               input logic [BYTE_W-1:0] fb, input logic [BYTE_W-1:0] sb,
                               input logic has2);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'({$urandom, $urandom});
         req_tuser  <= REQ_USER_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sb, fb, dir, spd, addr};
      req_tuser  <= {has2, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_command();
      int                  pick;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   fb;
      logic [BYTE_W-1:0]   sb;
      logic                has2;
      mode_type            mode;
      case ($urandom_range(3))
         0: addr = ADDR_W'($urandom_range(127));
         1: addr = ADDR_W'($urandom_range(10239, 128));
         2: addr = ADDR_W'($urandom_range(16383));
         default: addr = ($urandom_range(1) != 0) ? SHORT_ADDR_MAX : SHORT_ADDR_MAX + 1'b1;
      endcase
      fb   = BYTE_W'($urandom);
      sb   = BYTE_W'($urandom);
      has2 = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
         mode = MODE_THROTTLE;
      end else if (pick < 70) begin
         mode = MODE_FUNCTION;
         case ($urandom_range(9))
            0, 1: begin
               fb   = {TOP_GROUP_F0, fb[4:0]};
               has2 = 1'b0;
            end
            2, 3: begin
               fb   = {NIB_GROUP_F5, fb[3:0]};
               has2 = 1'b0;
            end
            4, 5: begin
               fb   = {NIB_GROUP_F9, fb[3:0]};
               has2 = 1'b0;
            end
            6, 7: begin
               fb   = fb[0] ? OP_EXP_F21 : OP_EXP_F13;
               has2 = 1'b1;
            end
            8: begin
               fb   = fb[0] ? OP_EXP_F21 : OP_EXP_F13;
               has2 = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (pick < 85) begin
         mode = MODE_REFRESH;
      end else begin
         mode = MODE_ESTOP;
      end
      send_command(mode, addr, SPEED_W'($urandom_range(127)), 1'($urandom), fb, sb, has2);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_packets != 0);
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_stall,
                            input int count);
      int n;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (n = 0; n < count; n++) begin
         send_random_command();
      end
      wait_drained();
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      hold_req   = 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state, address and speed extremes, saturation
      send_command(MODE_REFRESH,  14'd0,     7'd0,   1'b0, 8'h00, 8'h00, 1'b0);
      send_command(MODE_THROTTLE, 14'd0,     7'd0,   1'b0, 8'h00, 8'h00, 1'b0);
      send_command(MODE_THROTTLE, 14'd127,   7'd1,   1'b1, 8'hFF, 8'hFF, 1'b1);
      send_command(MODE_THROTTLE, 14'd128,   7'd126, 1'b1, 8'h00, 8'h00, 1'b0);
      send_command(MODE_THROTTLE, 14'h3FFF,  7'd127, 1'b0, 8'hFF, 8'hFF, 1'b1);
      send_command(MODE_THROTTLE, 14'd10239, 7'd127, 1'b1, 8'h00, 8'h00, 1'b0);
      // every function group, all on
      send_command(MODE_FUNCTION, 14'd3,     7'd0,   1'b0, 8'h9F, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd3,     7'd0,   1'b0, 8'hBF, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd3,     7'd0,   1'b0, 8'hAF, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd200,   7'd0,   1'b0, OP_EXP_F13, 8'hFF, 1'b1);
      send_command(MODE_FUNCTION, 14'd200,   7'd0,   1'b0, OP_EXP_F21, 8'hFF, 1'b1);
      // unrecognised bytes leave the functions alone; then all groups off except F13-F20
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, OP_EXP_F13, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, 8'hA5, 8'h00, 1'b1);
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, 8'hC0, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, 8'h80, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, 8'hB0, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, 8'hA0, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd5,     7'd0,   1'b0, OP_EXP_F21, 8'h00, 1'b1);
      // emergency stop shown in one burst then cleared, overridden by throttle, shown in a function burst
      send_command(MODE_THROTTLE, 14'd9,     7'd60,  1'b1, 8'h00, 8'h00, 1'b0);
      send_command(MODE_ESTOP,    14'h3FFF,  7'h7F,  1'b1, 8'hFF, 8'hFF, 1'b1);
      send_command(MODE_REFRESH,  14'h3FFF,  7'h7F,  1'b1, 8'hFF, 8'hFF, 1'b1);
      send_command(MODE_REFRESH,  14'd0,     7'd0,   1'b0, 8'h00, 8'h00, 1'b0);
      send_command(MODE_ESTOP,    14'd0,     7'd0,   1'b0, 8'h00, 8'h00, 1'b0);
      send_command(MODE_THROTTLE, 14'd9,     7'd40,  1'b0, 8'h00, 8'h00, 1'b0);
      send_command(MODE_ESTOP,    14'd0,     7'd0,   1'b0, 8'h00, 8'h00, 1'b0);
      send_command(MODE_FUNCTION, 14'd9,     7'd0,   1'b0, 8'h91, 8'h00, 1'b0);
      wait_drained();

      // receiver holds off while the sender keeps offering
      hold_req <= 1'b1;
      run_phase(0, 0, 30);
      run_phase(0, 0, 70);
      run_phase(87, 0, 70);
      run_phase(0, 87, 70);
      run_phase(12, 12, 70);

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_packets == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
